/* rtl/assert_macros.svh */
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with active-low reset disable
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition that must never hold at a clock edge
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  `ASSERT_PROP(lbl, clk, rstn, !(cond), msg)

`endif

/* rtl/gbs_pkg.sv */
// Package: widths, register map and types of the box suppression block
`timescale 1ns / 1ps

package gbs_pkg;

  localparam int MAX_KEPT  = 64;
  localparam int COORD_W   = 15;
  localparam int EDGE_W    = COORD_W + 1;
  localparam int LABEL_W   = 8;
  localparam int AREA_W    = 2 * COORD_W;
  localparam int INTER_W   = 2 * EDGE_W;
  localparam int THR_W     = 16;
  localparam int PROD_W    = THR_W + INTER_W;
  localparam int TOTAL_W   = 7;
  localparam int CNT_W     = ($clog2(MAX_KEPT + 1) > TOTAL_W) ? $clog2(MAX_KEPT + 1) : TOTAL_W;
  localparam int IDX_W     = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;

  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;
  localparam int REG_SEL_BIT = 2;

  localparam logic REG_THR = 1'b0;
  localparam logic REG_AGN = 1'b1;

  localparam logic [THR_W-1:0] THR_RESET = 16'd29491;

  typedef struct packed {
    logic [LABEL_W-1:0] label;
    logic [COORD_W-1:0] height;
    logic [COORD_W-1:0] width;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] left;
  } gbs_box_t;

  typedef struct packed {
    logic [LABEL_W-1:0] label;
    logic [AREA_W-1:0]  area;
    logic [COORD_W-1:0] height;
    logic [COORD_W-1:0] width;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] left;
  } gbs_entry_t;

  typedef struct packed {
    logic hit;
    logic busy;
  } gbs_iou_status_t;

endpackage

/* rtl/gbs_if.sv */
// Stream interfaces for box requests and suppression results
`timescale 1ns / 1ps

interface gbs_box_if;
  logic                        valid;
  logic                        ready;
  logic                        start_frame;
  logic [gbs_pkg::COORD_W-1:0] box_left;
  logic [gbs_pkg::COORD_W-1:0] box_top;
  logic [gbs_pkg::COORD_W-1:0] box_width;
  logic [gbs_pkg::COORD_W-1:0] box_height;
  logic [gbs_pkg::LABEL_W-1:0] class_label;

  modport source (output valid, start_frame, box_left, box_top, box_width, box_height,
                  class_label, input ready);
  modport sink   (input valid, start_frame, box_left, box_top, box_width, box_height,
                  class_label, output ready);
endinterface

interface gbs_res_if;
  logic                        valid;
  logic                        ready;
  logic                        keep;
  logic [gbs_pkg::TOTAL_W-1:0] kept_total;
  logic                        list_full;

  modport source (output valid, keep, kept_total, list_full, input ready);
  modport sink   (input valid, keep, kept_total, list_full, output ready);
endinterface

/* rtl/gbs_ram.sv */
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module gbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/gbs_iou_unit.sv */
// Pipelined overlap unit: intersection, union and threshold compare per kept box
`timescale 1ns / 1ps

module gbs_iou_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           vld_i,
  input  gbs_pkg::gbs_entry_t            entry_i,
  input  gbs_pkg::gbs_box_t              box_i,
  input  logic [gbs_pkg::AREA_W-1:0]     area_i,
  input  logic [gbs_pkg::THR_W-1:0]      thr_i,
  input  logic                           agnostic_i,
  output gbs_pkg::gbs_iou_status_t       status_o
);
  import gbs_pkg::*;

  logic [EDGE_W-1:0]  bx0, bx1, kx0, kx1, by0, by1, ky0, ky1;
  logic [EDGE_W-1:0]  lo_x, hi_x, lo_y, hi_y;
  logic [EDGE_W-1:0]  iw_d, ih_d;
  logic               match;

  logic               a_vld_q, b_vld_q, c_vld_q, d_vld_q;
  logic [EDGE_W-1:0]  a_iw_q, a_ih_q;
  logic [AREA_W-1:0]  a_karea_q, b_karea_q;
  logic [INTER_W-1:0] inter_d, b_inter_q, c_inter_q;
  logic [INTER_W-1:0] union_d, c_union_q;
  logic [PROD_W-1:0]  prod_d, d_prod_q, d_lhs_q;

  always_comb begin
    bx0  = {1'b0, box_i.left};
    bx1  = {1'b0, box_i.left} + {1'b0, box_i.width};
    kx0  = {1'b0, entry_i.left};
    kx1  = {1'b0, entry_i.left} + {1'b0, entry_i.width};
    by0  = {1'b0, box_i.top};
    by1  = {1'b0, box_i.top} + {1'b0, box_i.height};
    ky0  = {1'b0, entry_i.top};
    ky1  = {1'b0, entry_i.top} + {1'b0, entry_i.height};
    lo_x = (bx0 > kx0) ? bx0 : kx0;
    hi_x = (bx1 < kx1) ? bx1 : kx1;
    lo_y = (by0 > ky0) ? by0 : ky0;
    hi_y = (by1 < ky1) ? by1 : ky1;
    iw_d = (hi_x > lo_x) ? hi_x - lo_x : '0;
    ih_d = (hi_y > lo_y) ? hi_y - lo_y : '0;
    match = agnostic_i || (entry_i.label == box_i.label);
  end

  assign inter_d = a_iw_q * a_ih_q;
  assign union_d = INTER_W'(area_i) + INTER_W'(b_karea_q) - b_inter_q;
  assign prod_d  = thr_i * c_union_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
    end else begin
      a_vld_q <= vld_i && match;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_iw_q    <= iw_d;
    a_ih_q    <= ih_d;
    a_karea_q <= entry_i.area;
    b_inter_q <= inter_d;
    b_karea_q <= a_karea_q;
    c_union_q <= union_d;
    c_inter_q <= b_inter_q;
    d_prod_q  <= prod_d;
    d_lhs_q   <= {c_inter_q, {THR_W{1'b0}}};
  end

  assign status_o.hit  = d_vld_q && (d_lhs_q > d_prod_q);
  assign status_o.busy = a_vld_q || b_vld_q || c_vld_q || d_vld_q;

endmodule

/* rtl/greedy_box_suppression.sv */
// Top level: greedy box suppression with kept-box store and register port
//
//  channel   dir   handshake               payload
//  box_i     in    valid/ready             start_frame, box_left/top/width/height, class_label
//  res_o     out   valid/ready             keep, kept_total, list_full
//  apb       in    psel/penable, pready=1  paddr, pwdata, prdata
//
// Each box is compared against the N kept boxes in the list (up to 64), then waits
// while compared boxes drain from the four-stage overlap unit.
// No clearing pass after reset; the kept count bounds every read.
// A waiting result holds in the output register; the next box is taken meanwhile.
`timescale 1ns / 1ps

module greedy_box_suppression (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  gbs_box_if.sink                    box_i,
  gbs_res_if.source                  res_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [gbs_pkg::APB_AW-1:0] paddr,
  input  logic [gbs_pkg::APB_DW-1:0] pwdata,
  output logic [gbs_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import gbs_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [THR_W-1:0]   thr_q;
  logic               agn_q;
  gbs_box_t           box_q;
  logic [AREA_W-1:0]  area_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   issue_q, issue_d;
  logic               supp_q, supp_d;
  logic               rd_vld_q;
  logic               re;
  logic               we;
  logic               accept;
  logic               load;
  logic               keep;
  logic               full;
  logic [CNT_W-1:0]   new_count;
  logic               out_vld_q, out_vld_d;
  logic               out_keep_q, out_full_q;
  logic [TOTAL_W-1:0] out_total_q;
  logic               cfg_wr;
  gbs_entry_t         wr_entry;
  gbs_entry_t         rd_entry;
  gbs_iou_status_t    iou_st;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
      agn_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[REG_SEL_BIT])
        REG_THR: thr_q <= pwdata[THR_W-1:0];
        REG_AGN: agn_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[REG_SEL_BIT])
      REG_THR: prdata = APB_DW'(thr_q);
      REG_AGN: prdata = APB_DW'(agn_q);
      default: prdata = '0;
    endcase
  end

  assign box_i.ready = (state_q == ST_IDLE);
  assign accept      = box_i.valid && box_i.ready;

  assign keep      = !supp_q;
  assign full      = keep && (count_q == CNT_W'(MAX_KEPT));
  assign load      = (state_q == ST_DONE) && (!out_vld_q || res_o.ready);
  assign we        = load && keep && !full;
  assign new_count = we ? count_q + CNT_W'(1) : count_q;

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    issue_d = issue_q;
    supp_d  = supp_q || iou_st.hit;
    re      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (box_i.start_frame) begin
            count_d = '0;
          end
          issue_d = '0;
          supp_d  = 1'b0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issue_q == count_q) begin
          state_d = ST_DRAIN;
        end else begin
          re      = 1'b1;
          issue_d = issue_q + CNT_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!rd_vld_q && !iou_st.busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load) begin
          count_d = new_count;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (load) begin
      out_vld_d = 1'b1;
    end else if (res_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      issue_q   <= '0;
      supp_q    <= 1'b0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      issue_q   <= issue_d;
      supp_q    <= supp_d;
      rd_vld_q  <= re;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      box_q.left   <= box_i.box_left;
      box_q.top    <= box_i.box_top;
      box_q.width  <= box_i.box_width;
      box_q.height <= box_i.box_height;
      box_q.label  <= box_i.class_label;
    end
    area_q <= box_q.width * box_q.height;
    if (load) begin
      out_keep_q  <= keep;
      out_full_q  <= full;
      out_total_q <= new_count[TOTAL_W-1:0];
    end
  end

  assign res_o.valid      = out_vld_q;
  assign res_o.keep       = out_keep_q;
  assign res_o.list_full  = out_full_q;
  assign res_o.kept_total = out_total_q;

  always_comb begin
    wr_entry.left   = box_q.left;
    wr_entry.top    = box_q.top;
    wr_entry.width  = box_q.width;
    wr_entry.height = box_q.height;
    wr_entry.label  = box_q.label;
    wr_entry.area   = area_q;
  end

  gbs_ram #(
    .WIDTH ($bits(gbs_entry_t)),
    .DEPTH (MAX_KEPT)
  ) u_kept_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (wr_entry),
    .re_i    (re),
    .raddr_i (issue_q[IDX_W-1:0]),
    .rdata_o (rd_entry)
  );

  gbs_iou_unit u_iou (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .vld_i      (rd_vld_q),
    .entry_i    (rd_entry),
    .box_i      (box_q),
    .area_i     (area_q),
    .thr_i      (thr_q),
    .agnostic_i (agn_q),
    .status_o   (iou_st)
  );

endmodule

/* rtl/gbs_checker.sv */
// Port-level checker for the box suppression top level, with its bind
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gbs_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        box_valid_i,
  input logic                        box_ready_i,
  input logic                        res_valid_i,
  input logic                        res_ready_i,
  input logic                        keep_i,
  input logic                        list_full_i,
  input logic [gbs_pkg::TOTAL_W-1:0] kept_total_i
);
  import gbs_pkg::*;

  localparam logic [TOTAL_W-1:0] FULL_TOTAL = TOTAL_W'(MAX_KEPT % (1 << TOTAL_W));

  `ASSERT_PROP(a_busy_after_req, clk_i, rst_ni, (box_valid_i && box_ready_i) |=> !box_ready_i, "box taken while previous request in progress")

  `ASSERT_NEVER(a_full_consistent, clk_i, rst_ni, res_valid_i && list_full_i && (!keep_i || kept_total_i != FULL_TOTAL), "list_full without keep or full list")

  `ASSERT_NEVER(a_total_range, clk_i, rst_ni, res_valid_i && (CNT_W'(kept_total_i) > CNT_W'(MAX_KEPT)), "kept_total above list size")

  `ASSERT_PROP(a_res_hold, clk_i, rst_ni, (res_valid_i && !res_ready_i) |=> res_valid_i, "result dropped while stalled")

endmodule

bind greedy_box_suppression gbs_checker u_gbs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .box_valid_i  (box_i.valid),
  .box_ready_i  (box_i.ready),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .keep_i       (res_o.keep),
  .list_full_i  (res_o.list_full),
  .kept_total_i (res_o.kept_total)
);

/* tb/testbench.sv */
// Testbench for greedy_box_suppression: directed table, then random frames checked by a predictor
`timescale 1ns / 1ps

module testbench;
  import gbs_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES    = 80;
  localparam int COORD_MAX      = (1 << COORD_W) - 1;
  localparam logic [APB_AW-1:0] ADDR_THR = APB_AW'(REG_THR) << REG_SEL_BIT;
  localparam logic [APB_AW-1:0] ADDR_AGN = APB_AW'(REG_AGN) << REG_SEL_BIT;

  typedef struct packed {
    logic     start_frame;
    gbs_box_t box;
  } box_req_t;

  typedef struct packed {
    logic               keep;
    logic [TOTAL_W-1:0] kept_total;
    logic               list_full;
  } verdict_t;

  typedef enum logic [1:0] {ROW_BOX, ROW_SET_THR, ROW_SET_AGN} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [31:0] wdata;
    box_req_t    req;
    logic        typed;
    verdict_t    want;
  } row_t;

  typedef enum logic [2:0] {FR_CLUSTER, FR_BROKEN, FR_FLAT, FR_CROWDED, FR_NOISE} frame_kind_e;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel, penable, pwrite, pready;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata, prdata;

  gbs_box_if box_if ();
  gbs_res_if res_if ();

  greedy_box_suppression dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .box_i   (box_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state and register mirror
  gbs_entry_t        kept_list [MAX_KEPT];
  int unsigned       kept_n;
  logic [THR_W-1:0]  thr_q;
  logic              agnostic_q;

  verdict_t expected_verdicts [$];
  row_t     dir_rows [$];

  int errors;
  int n_boxes, n_frames, n_kept, n_suppressed, n_full, n_settings;
  int stall_left;
  int quiet_cycles;
  logic no_idle;
  verdict_t got_v, exp_v;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic logic [31:0] span_overlap(logic [31:0] a0, logic [31:0] a1,
                                               logic [31:0] b0, logic [31:0] b1);
    logic [31:0] lo, hi;
    lo = (a0 > b0) ? a0 : b0;
    hi = (a1 < b1) ? a1 : b1;
    return (hi > lo) ? hi - lo : 32'd0;
  endfunction

  function automatic verdict_t predict_suppression(box_req_t r);
    verdict_t    v;
    gbs_entry_t  k;
    logic [31:0] area, iw, ih;
    logic [63:0] inter, uni;
    v.keep      = 1'b1;
    v.list_full = 1'b0;
    if (r.start_frame) kept_n = 0;
    area = 32'(r.box.width) * 32'(r.box.height);
    for (int i = 0; i < kept_n; i++) begin
      k = kept_list[i];
      if (!agnostic_q && k.label != r.box.label) continue;
      iw = span_overlap(32'(r.box.left), 32'(r.box.left) + 32'(r.box.width),
                        32'(k.left), 32'(k.left) + 32'(k.width));
      ih = span_overlap(32'(r.box.top), 32'(r.box.top) + 32'(r.box.height),
                        32'(k.top), 32'(k.top) + 32'(k.height));
      inter = 64'(iw) * 64'(ih);
      uni   = 64'(area) + 64'(k.area) - inter;
      if ((inter << 16) > 64'(thr_q) * uni) v.keep = 1'b0;
    end
    if (v.keep) begin
      if (kept_n >= MAX_KEPT) begin
        v.list_full = 1'b1;
      end else begin
        kept_list[kept_n] = '{label: r.box.label, area: area[AREA_W-1:0],
                              height: r.box.height, width: r.box.width,
                              top: r.box.top, left: r.box.left};
        kept_n++;
      end
    end
    v.kept_total = TOTAL_W'(kept_n);
    return v;
  endfunction

  function automatic int idle_gap();
    if (no_idle || $urandom_range(0, 3) != 0) return 0;
    return $urandom_range(1, 15);
  endfunction

  function automatic logic [COORD_W-1:0] clamp_coord(int v);
    if (v < 0) return '0;
    if (v > COORD_MAX) return COORD_W'(COORD_MAX);
    return COORD_W'(v);
  endfunction

  function automatic row_t box_row(logic sf, int l, int t, int w, int h, int lbl,
                                   logic typed, logic keep, int total, logic full);
    row_t row;
    row.kind              = ROW_BOX;
    row.wdata             = '0;
    row.req.start_frame   = sf;
    row.req.box.left      = COORD_W'(l);
    row.req.box.top       = COORD_W'(t);
    row.req.box.width     = COORD_W'(w);
    row.req.box.height    = COORD_W'(h);
    row.req.box.label     = LABEL_W'(lbl);
    row.typed             = typed;
    row.want.keep         = keep;
    row.want.kept_total   = TOTAL_W'(total);
    row.want.list_full    = full;
    return row;
  endfunction

  function automatic row_t cfg_row(row_kind_e kind, logic [31:0] wdata);
    row_t row;
    row       = box_row(1'b0, 0, 0, 0, 0, 0, 1'b0, 1'b0, 0, 1'b0);
    row.kind  = kind;
    row.wdata = wdata;
    return row;
  endfunction

  // append a row to the directed table
  function automatic void add_row(row_t row);
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  // request channel: called and left at a falling edge
  task automatic push_box(box_req_t r, logic typed, verdict_t want);
    int gap;
    verdict_t v;
    gap = idle_gap();
    if (gap > 0) begin
      box_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    box_if.valid       = 1'b1;
    box_if.start_frame = r.start_frame;
    box_if.box_left    = r.box.left;
    box_if.box_top     = r.box.top;
    box_if.box_width   = r.box.width;
    box_if.box_height  = r.box.height;
    box_if.class_label = r.box.label;
    do @(posedge clk_i); while (!box_if.ready);
    v = predict_suppression(r);
    expected_verdicts.insert(expected_verdicts.size(), typed ? want : v);
    n_boxes++;
    if (r.start_frame) n_frames++;
    if (!v.keep) n_suppressed++;
    else n_kept++;
    if (v.list_full) n_full++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    box_if.valid = 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic check_reg(logic [APB_AW-1:0] addr);
    logic [31:0] want;
    want = (addr == ADDR_THR) ? 32'(thr_q) : 32'(agnostic_q);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = addr;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) begin
      $display("%0t register at 0x%0h: expected %0d actual %0d", $time, addr, want, prdata);
      errors++;
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic write_reg(logic [APB_AW-1:0] addr, logic [31:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == ADDR_THR) thr_q = data[THR_W-1:0];
    else if (addr == ADDR_AGN) agnostic_q = data[0];
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    n_settings++;
    check_reg(addr);
  endtask

  task automatic run_frame();
    frame_kind_e kind;
    int n, ncent, jit, c, lbl, base_x, base_y;
    int cx [4], cy [4], cw [4], ch [4], cl [4];
    logic wide_labels;
    box_req_t r;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9: kind = FR_CLUSTER;
      10, 11, 12:                   kind = FR_BROKEN;
      13, 14:                       kind = FR_FLAT;
      15, 16:                       kind = FR_CROWDED;
      default:                      kind = FR_NOISE;
    endcase
    wide_labels = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < 4; i++) begin
      cx[i] = $urandom_range(0, 30000);
      cy[i] = $urandom_range(0, 30000);
      cw[i] = $urandom_range(16, 3000);
      ch[i] = $urandom_range(16, 3000);
      cl[i] = wide_labels ? $urandom_range(0, 255) : $urandom_range(0, 3);
    end
    ncent = $urandom_range(1, 4);
    jit   = ($urandom_range(0, 3) == 0) ? 2000 : $urandom_range(4, 200);
    case (kind)
      FR_CROWDED: n = $urandom_range(65, 72);
      FR_NOISE:   n = $urandom_range(1, 8);
      default:    n = $urandom_range(1, 40);
    endcase
    base_x = $urandom_range(0, COORD_MAX - 9 * 64);
    base_y = $urandom_range(0, COORD_MAX - 10 * 64);
    lbl    = $urandom_range(0, 255);
    for (int i = 0; i < n; i++) begin
      c = $urandom_range(0, ncent - 1);
      r.start_frame = (i == 0);
      r.box.left    = clamp_coord(cx[c] + $urandom_range(0, 2 * jit) - jit);
      r.box.top     = clamp_coord(cy[c] + $urandom_range(0, 2 * jit) - jit);
      r.box.width   = clamp_coord(cw[c] + $urandom_range(0, 2 * jit) - jit);
      r.box.height  = clamp_coord(ch[c] + $urandom_range(0, 2 * jit) - jit);
      r.box.label   = LABEL_W'(cl[c]);
      case (kind)
        FR_BROKEN: begin
          if (i > 0 && $urandom_range(0, 4) == 0) r.start_frame = 1'b1;
        end
        FR_FLAT: begin
          if ($urandom_range(0, 1) == 0) r.box.width = '0;
          else r.box.height = '0;
        end
        FR_CROWDED: begin
          r.box.left   = COORD_W'(base_x + (i % 8) * 64);
          r.box.top    = COORD_W'(base_y + (i / 8) * 64);
          r.box.width  = COORD_W'($urandom_range(1, 48));
          r.box.height = COORD_W'($urandom_range(1, 48));
          r.box.label  = LABEL_W'(lbl);
        end
        FR_NOISE: begin
          r.start_frame = 1'($urandom);
          r.box.left    = COORD_W'($urandom);
          r.box.top     = COORD_W'($urandom);
          r.box.width   = COORD_W'($urandom);
          r.box.height  = COORD_W'($urandom);
          r.box.label   = LABEL_W'($urandom);
        end
        default: ;
      endcase
      push_box(r, 1'b0, '0);
    end
  endtask

  task automatic run_phase(logic [THR_W-1:0] thr, logic agn, int quota);
    int start;
    drain();
    write_reg(ADDR_THR, ($urandom & 32'hFFFF_0000) | 32'(thr));
    write_reg(ADDR_AGN, ($urandom & 32'hFFFF_FFFE) | 32'(agn));
    start = n_boxes;
    while (n_boxes - start < quota) begin
      run_frame();
      if ($urandom_range(0, 24) == 0) drain();
    end
  endtask

  always @(negedge clk_i) begin
    if (stall_left > 0 && !no_idle) begin
      res_if.ready = 1'b0;
      stall_left--;
    end else begin
      res_if.ready = 1'b1;
      if (!no_idle && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 15);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      got_v = '{keep: res_if.keep, kept_total: res_if.kept_total,
                list_full: res_if.list_full};
      if (expected_verdicts.size() == 0) begin
        $display("%0t unexpected result: expected none actual keep=%0d total=%0d full=%0d",
                 $time, got_v.keep, got_v.kept_total, got_v.list_full);
        errors++;
      end else begin
        exp_v = expected_verdicts.pop_front();
        if (got_v.keep !== exp_v.keep) begin
          $display("%0t keep: expected %0d actual %0d", $time, exp_v.keep, got_v.keep);
          errors++;
        end
        if (got_v.kept_total !== exp_v.kept_total) begin
          $display("%0t kept_total: expected %0d actual %0d", $time,
                   exp_v.kept_total, got_v.kept_total);
          errors++;
        end
        if (got_v.list_full !== exp_v.list_full) begin
          $display("%0t list_full: expected %0d actual %0d", $time,
                   exp_v.list_full, got_v.list_full);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((box_if.valid && box_if.ready) || (res_if.valid && res_if.ready) || psel)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t no request or result moved for %0d cycles", $time, quiet_cycles);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst_ni             = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    box_if.valid       = 1'b0;
    box_if.start_frame = 1'b0;
    box_if.box_left    = '0;
    box_if.box_top     = '0;
    box_if.box_width   = '0;
    box_if.box_height  = '0;
    box_if.class_label = '0;
    res_if.ready       = 1'b0;
    stall_left         = 0;
    quiet_cycles       = 0;
    no_idle            = 1'b0;
    errors             = 0;
    n_boxes            = 0;
    n_frames           = 0;
    n_kept             = 0;
    n_suppressed       = 0;
    n_full             = 0;
    n_settings         = 0;
    kept_n             = 0;
    thr_q              = THR_RESET;
    agnostic_q         = 1'b0;

    // sf, left, top, width, height, label, typed, keep, total, full
    add_row(box_row(1, 0, 0, 256, 256, 0, 1, 1, 1, 0));
    add_row(box_row(0, 0, 0, 256, 256, 0, 1, 0, 1, 0));
    add_row(box_row(0, 0, 0, 256, 256, 1, 1, 1, 2, 0));
    add_row(box_row(0, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 255,
                    1, 1, 3, 0));
    add_row(box_row(0, 256, 0, 256, 256, 0, 1, 1, 4, 0));
    add_row(box_row(0, 128, 128, 0, 0, 0, 1, 1, 5, 0));
    add_row(box_row(0, 128, 128, 0, 0, 0, 1, 1, 6, 0));
    add_row(box_row(1, 0, 0, 0, 0, 255, 1, 1, 1, 0));
    add_row(cfg_row(ROW_SET_THR, 32'hFFFF_0000));
    add_row(box_row(1, 1600, 1600, 1024, 1024, 7, 1, 1, 1, 0));
    add_row(box_row(0, 2623, 2623, 1024, 1024, 7, 1, 0, 1, 0));
    add_row(box_row(0, 2624, 1600, 1024, 1024, 7, 1, 1, 2, 0));
    add_row(cfg_row(ROW_SET_THR, 32'hABCD_FFFF));
    add_row(box_row(1, 0, 0, COORD_MAX, COORD_MAX, 3, 1, 1, 1, 0));
    add_row(box_row(0, 0, 0, COORD_MAX, COORD_MAX, 3, 1, 0, 1, 0));
    add_row(box_row(0, 16, 16, COORD_MAX, COORD_MAX - 16, 3, 0, 0, 0, 0));
    add_row(cfg_row(ROW_SET_AGN, 32'hFFFF_FFFF));
    add_row(cfg_row(ROW_SET_THR, 32'h0001_8000));
    add_row(box_row(1, 0, 0, 1024, 1024, 1, 1, 1, 1, 0));
    add_row(box_row(0, 0, 0, 1024, 1024, 2, 1, 0, 1, 0));
    add_row(box_row(0, 0, 512, 1024, 1024, 9, 0, 0, 0, 0));
    add_row(box_row(0, 0, 0, 1024, 768, 5, 0, 0, 0, 0));
    add_row(cfg_row(ROW_SET_AGN, 32'hFFFF_FFFE));
    add_row(box_row(0, 0, 0, 1024, 1024, 2, 0, 0, 0, 0));
    add_row(box_row(0, 0, 0, 1024, 1024, 9, 0, 0, 0, 0));

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    check_reg(ADDR_THR);
    check_reg(ADDR_AGN);

    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_BOX: push_box(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
        ROW_SET_THR: begin
          drain();
          write_reg(ADDR_THR, dir_rows[i].wdata);
        end
        ROW_SET_AGN: begin
          drain();
          write_reg(ADDR_AGN, dir_rows[i].wdata);
        end
        default: ;
      endcase
    end

    run_phase(THR_RESET, 1'b0, 280);
    run_phase('0, 1'b1, 280);
    run_phase('1, 1'b0, 280);
    run_phase(THR_W'($urandom), 1'b1, 280);
    run_phase(THR_W'($urandom), 1'b0, 280);
    drain();
    no_idle = 1'b1;
    run_phase(16'd32768, 1'b1, 200);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Covered %0d boxes in %0d frames under %0d register writes.",
             n_boxes, n_frames, n_settings);
    $display("Outcomes: %0d kept, %0d suppressed, %0d kept past a full list; %0d mismatches.",
             n_kept, n_suppressed, n_full, errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
